@@ rtl/multihop_node_count_aggregator_top_macros.svh @@
// assertion macros shared by the checker of the node count aggregator
`ifndef MULTIHOP_NODE_COUNT_AGGREGATOR_TOP_MACROS_SVH
`define MULTIHOP_NODE_COUNT_AGGREGATOR_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define MNCA_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mnca assertion failed");

// next-cycle implication, disabled while reset is high
`define MNCA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mnca assertion failed");

`endif

@@ rtl/mnca_pkg.sv @@
// shared types and constants of the node count aggregator
`default_nettype none

package mnca_pkg;

   // field widths
   localparam int MODE_W      = 2;
   localparam int LEVEL_W     = 8;
   localparam int COUNT_W     = 8;
   localparam int PARENTS_W   = 7;
   localparam int TIME_W      = 16;
   localparam int RAND_W      = 16;
   localparam int SLOT_W      = 6;
   localparam int ID_W        = 16;
   localparam int EPOCH_W     = 15;
   localparam int LIMIT_W     = 7;
   localparam int KIND_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // send slot sits in bits 13..8 of the random word
   localparam int SLOT_LSB = 8;

   // event codes
   localparam logic [MODE_W-1:0] MODE_COUNT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DONE  = 2'd3;

   // send kinds
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REPORT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_ID      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EPOCH_SPAN   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPIRE_LIMIT = 2'd2;

   // reset values
   localparam logic [LEVEL_W-1:0] LEVEL_NONE         = 8'hFF;
   localparam logic [EPOCH_W-1:0] EPOCH_SPAN_RESET   = 15'd64;
   localparam logic [LIMIT_W-1:0] EXPIRE_LIMIT_RESET = 7'd10;

   // shared divider: two quotient bits per cycle
   localparam int                  DIV_BITS_PER_CYCLE = 2;
   localparam int                  DIV_DIVIDEND_W     = 16;
   localparam int                  DIV_QUOTIENT_W     = 8;
   localparam int                  DIV_STEP_W         = 4;
   localparam logic [DIV_STEP_W-1:0] DIV_STEPS_BYTE   = 4'd4;
   localparam logic [DIV_STEP_W-1:0] DIV_STEPS_WORD   = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV_QUO,
      ST_DIV_PICK,
      ST_FINISH
   } fsm_state_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
   } div_ctrl_type;

   typedef struct packed {
      logic                      done;
      logic [DIV_QUOTIENT_W-1:0] quotient;
      logic [PARENTS_W-1:0]      remainder;
   } div_stat_type;

   typedef struct packed {
      logic [KIND_W-1:0]    send_kind;
      logic [LEVEL_W-1:0]   out_level;
      logic [COUNT_W-1:0]   out_count;
      logic [PARENTS_W-1:0] out_parents;
      logic [SLOT_W-1:0]    out_slot;
      logic [TIME_W-1:0]    out_remaining;
      logic [ID_W-1:0]      out_id;
      logic [TIME_W-1:0]    out_clock;
      logic                 clock_on;
   } rsp_payload_type;

endpackage

`default_nettype wire

@@ rtl/mnca_channels.sv @@
// valid/ready channel interfaces for events in and results out
`default_nettype none

interface mnca_req_if;
   logic                                       valid;
   logic                                       ready;
   logic        [mnca_pkg::MODE_W-1:0]         mode;
   logic signed [mnca_pkg::LEVEL_W-1:0]        msg_level;
   logic signed [mnca_pkg::COUNT_W-1:0]        msg_count;
   logic        [mnca_pkg::PARENTS_W-1:0]      msg_parents;
   logic signed [mnca_pkg::TIME_W-1:0]         msg_remaining;
   logic        [mnca_pkg::TIME_W-1:0]         now_time;
   logic        [mnca_pkg::RAND_W-1:0]         rand_slot;
   logic        [mnca_pkg::RAND_W-1:0]         rand_pick;
   logic                                       send_accepted;

   modport source (
      output valid, mode, msg_level, msg_count, msg_parents, msg_remaining,
             now_time, rand_slot, rand_pick, send_accepted,
      input  ready
   );

   modport sink (
      input  valid, mode, msg_level, msg_count, msg_parents, msg_remaining,
             now_time, rand_slot, rand_pick, send_accepted,
      output ready
   );
endinterface

interface mnca_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic        [mnca_pkg::KIND_W-1:0]         send_kind;
   logic signed [mnca_pkg::LEVEL_W-1:0]        out_level;
   logic signed [mnca_pkg::COUNT_W-1:0]        out_count;
   logic        [mnca_pkg::PARENTS_W-1:0]      out_parents;
   logic        [mnca_pkg::SLOT_W-1:0]         out_slot;
   logic signed [mnca_pkg::TIME_W-1:0]         out_remaining;
   logic        [mnca_pkg::ID_W-1:0]           out_id;
   logic        [mnca_pkg::TIME_W-1:0]         out_clock;
   logic                                       clock_on;

   modport source (
      output valid, send_kind, out_level, out_count, out_parents, out_slot,
             out_remaining, out_id, out_clock, clock_on,
      input  ready
   );

   modport sink (
      input  valid, send_kind, out_level, out_count, out_parents, out_slot,
             out_remaining, out_id, out_clock, clock_on,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/multihop_node_count_aggregator_top.sv @@
// Epoch-based node counter: one event in, one result beat out.
// Each event passes evaluate and finish; its result beat is registered once the output
// register is free. A child count message with nonzero parents also takes two passes of
// the shared divider (4 then 8 steps, each then flagging done) before finish.
// New events are taken only in idle, once the last result is in the output register.
// Reset: synchronous, active high; clears control, configuration and node state.
`default_nettype none

module multihop_node_count_aggregator_top (
   input  wire                                   clock,
   input  wire                                   reset,
   mnca_req_if.sink                              req_bus,
   mnca_rsp_if.source                            rsp_bus,
   input  wire                                   csr_we,
   input  wire [mnca_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [mnca_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // sequencer
   mnca_pkg::fsm_state_type state_ff, state_in;

   // configuration
   logic [mnca_pkg::ID_W-1:0]    node_id_ff;
   logic [mnca_pkg::EPOCH_W-1:0] epoch_span_ff;
   logic [mnca_pkg::LIMIT_W-1:0] expire_limit_ff;

   // captured event
   logic [mnca_pkg::MODE_W-1:0]    mode_ff;
   logic [mnca_pkg::LEVEL_W-1:0]   msg_level_ff;
   logic [mnca_pkg::COUNT_W-1:0]   msg_count_ff;
   logic [mnca_pkg::PARENTS_W-1:0] msg_parents_ff;
   logic [mnca_pkg::TIME_W-1:0]    msg_remaining_ff;
   logic [mnca_pkg::TIME_W-1:0]    now_ff;
   logic [mnca_pkg::SLOT_W-1:0]    slot_pick_ff;
   logic [mnca_pkg::RAND_W-1:0]    rand_pick_ff;
   logic                           send_accepted_ff;

   // node state
   logic [mnca_pkg::LEVEL_W-1:0] hop_level_ff, hop_level_in;
   logic [mnca_pkg::LEVEL_W-1:0] prev_level_ff, prev_level_in;
   logic [mnca_pkg::COUNT_W-1:0] child_tally_ff, child_tally_in;
   logic [mnca_pkg::COUNT_W-1:0] parent_tally_ff, parent_tally_in;
   logic [mnca_pkg::COUNT_W-1:0] prev_children_ff, prev_children_in;
   logic [mnca_pkg::COUNT_W-1:0] prev_parents_ff, prev_parents_in;
   logic [mnca_pkg::COUNT_W-1:0] idle_epochs_ff, idle_epochs_in;
   logic                         send_pending_ff, send_pending_in;
   logic                         sent_ff, sent_in;
   logic                         node_active_ff, node_active_in;
   logic [mnca_pkg::SLOT_W-1:0]  send_slot_ff, send_slot_in;
   logic [mnca_pkg::TIME_W-1:0]  epoch_start_ff, epoch_start_in;

   // first divider pass results
   logic [mnca_pkg::DIV_QUOTIENT_W-1:0] quo_ff, quo_in;
   logic [mnca_pkg::PARENTS_W-1:0]      rem_ff, rem_in;

   // staged result and output register
   mnca_pkg::rsp_payload_type res_ff, res_in;
   mnca_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // divider hookup
   mnca_pkg::div_ctrl_type              div_ctrl;
   mnca_pkg::div_stat_type              div_stat;
   logic [mnca_pkg::DIV_DIVIDEND_W-1:0] div_dividend;

   // derived event values
   logic                           take_beat;
   logic [mnca_pkg::TIME_W-1:0]    start_eff;
   logic [mnca_pkg::TIME_W-1:0]    elapsed;
   logic [mnca_pkg::TIME_W-1:0]    elapsed_eff;
   logic [mnca_pkg::TIME_W:0]      remaining_wide;
   logic [mnca_pkg::TIME_W-1:0]    remaining;
   logic                           rem_le_zero;
   logic                           before_slot;
   logic [mnca_pkg::LEVEL_W:0]     level_up;
   logic [mnca_pkg::LEVEL_W:0]     level_down;
   logic                           hop_none;
   logic                           prev_none;
   logic                           hop_wins;
   logic [mnca_pkg::LEVEL_W-1:0]   hop_new;
   logic                           from_parent;
   logic                           from_child;
   logic [mnca_pkg::TIME_W-1:0]    sync_start;
   logic [mnca_pkg::COUNT_W-1:0]   idle_next;
   logic                           expired;
   logic [mnca_pkg::COUNT_W-1:0]   count_abs;
   logic [mnca_pkg::COUNT_W-1:0]   share;
   logic                           round_up;

   assign take_beat     = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == mnca_pkg::ST_IDLE);

   // remaining ticks in the epoch, with negative elapsed time read as a full epoch
   assign start_eff      = (mode_ff == mnca_pkg::MODE_COUNT && !node_active_ff) ?
                           now_ff : epoch_start_ff;
   assign elapsed        = now_ff - start_eff;
   assign elapsed_eff    = elapsed[mnca_pkg::TIME_W-1] ? {1'b0, epoch_span_ff} : elapsed;
   assign remaining_wide = {2'b00, epoch_span_ff} - {1'b0, elapsed_eff};
   assign remaining      = remaining_wide[mnca_pkg::TIME_W-1:0];
   assign rem_le_zero    = remaining[mnca_pkg::TIME_W-1] || (remaining == '0);
   assign before_slot    = (elapsed_eff < {{(mnca_pkg::TIME_W-mnca_pkg::SLOT_W){1'b0}},
                                            send_slot_ff});

   // level compare at 9 bits
   assign level_up    = {msg_level_ff[mnca_pkg::LEVEL_W-1], msg_level_ff} + 1'b1;
   assign level_down  = {msg_level_ff[mnca_pkg::LEVEL_W-1], msg_level_ff} - 1'b1;
   assign hop_none    = (hop_level_ff == mnca_pkg::LEVEL_NONE);
   assign prev_none   = (prev_level_ff == mnca_pkg::LEVEL_NONE);
   assign hop_wins    = hop_none ||
                        ($signed(level_up) <
                         $signed({hop_level_ff[mnca_pkg::LEVEL_W-1], hop_level_ff}));
   assign hop_new     = hop_wins ? level_up[mnca_pkg::LEVEL_W-1:0] : hop_level_ff;
   assign from_parent = ({hop_new[mnca_pkg::LEVEL_W-1], hop_new} == level_up);
   assign from_child  = ({prev_level_ff[mnca_pkg::LEVEL_W-1], prev_level_ff} == level_down);

   // parent time sync: start = now - (epoch span - sender remaining)
   assign sync_start = now_ff - {1'b0, epoch_span_ff} + msg_remaining_ff;

   // idle epoch count and expiry, signed compare
   assign idle_next = idle_epochs_ff + 1'b1;
   assign expired   = ($signed(idle_next) > $signed({1'b0, expire_limit_ff}));

   // signed split from unsigned magnitude pass and random pick pass
   assign count_abs = msg_count_ff[mnca_pkg::COUNT_W-1] ? ('0 - msg_count_ff) : msg_count_ff;
   assign share     = msg_count_ff[mnca_pkg::COUNT_W-1] ? ('0 - quo_ff) : quo_ff;
   assign round_up  = !msg_count_ff[mnca_pkg::COUNT_W-1] && (rem_ff > div_stat.remainder);

   // sequencer and state update
   always_comb begin
      state_in         = state_ff;
      hop_level_in     = hop_level_ff;
      prev_level_in    = prev_level_ff;
      child_tally_in   = child_tally_ff;
      parent_tally_in  = parent_tally_ff;
      prev_children_in = prev_children_ff;
      prev_parents_in  = prev_parents_ff;
      idle_epochs_in   = idle_epochs_ff;
      send_pending_in  = send_pending_ff;
      sent_in          = sent_ff;
      node_active_in   = node_active_ff;
      send_slot_in     = send_slot_ff;
      epoch_start_in   = epoch_start_ff;
      quo_in           = quo_ff;
      rem_in           = rem_ff;
      res_in           = res_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff;
      div_ctrl.start   = 1'b0;
      div_ctrl.steps   = mnca_pkg::DIV_STEPS_BYTE;
      div_dividend     = {count_abs, {(mnca_pkg::DIV_DIVIDEND_W-mnca_pkg::COUNT_W){1'b0}}};

      // output register drains on a taken beat
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         mnca_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = mnca_pkg::ST_EVAL;
            end
         end

         mnca_pkg::ST_EVAL: begin
            state_in = mnca_pkg::ST_FINISH;
            res_in   = '0;
            case (mode_ff)
               mnca_pkg::MODE_COUNT: begin
                  // first contact wakes the node
                  if (!node_active_ff) begin
                     send_slot_in   = slot_pick_ff;
                     epoch_start_in = now_ff;
                     node_active_in = 1'b1;
                  end
                  hop_level_in = hop_new;
                  if (from_parent) begin
                     if (remaining != msg_remaining_ff) begin
                        epoch_start_in = sync_start;
                     end
                     parent_tally_in = parent_tally_ff + 1'b1;
                     idle_epochs_in  = '0;
                  end else if (from_child) begin
                     if (msg_parents_ff == '0) begin
                        child_tally_in = child_tally_ff + msg_count_ff;
                     end else begin
                        div_ctrl.start = 1'b1;
                        state_in       = mnca_pkg::ST_DIV_QUO;
                     end
                  end
               end

               mnca_pkg::MODE_TICK: begin
                  if (node_active_ff) begin
                     if (rem_le_zero && (sent_ff || prev_none)) begin
                        // epoch rollover
                        sent_in          = 1'b0;
                        send_slot_in     = slot_pick_ff;
                        epoch_start_in   = now_ff + remaining;
                        prev_level_in    = hop_level_ff;
                        prev_children_in = child_tally_ff;
                        prev_parents_in  = parent_tally_ff;
                        child_tally_in   = '0;
                        parent_tally_in  = '0;
                        idle_epochs_in   = idle_next;
                        if (expired) begin
                           hop_level_in   = mnca_pkg::LEVEL_NONE;
                           prev_level_in  = mnca_pkg::LEVEL_NONE;
                           node_active_in = 1'b0;
                        end
                     end else if (!prev_none && !sent_ff && !(before_slot && !rem_le_zero) &&
                                  !send_pending_ff && send_accepted_ff) begin
                        // count report in our slot
                        send_pending_in       = 1'b1;
                        sent_in               = 1'b1;
                        res_in.send_kind      = mnca_pkg::KIND_REPORT;
                        res_in.out_level      = prev_level_ff;
                        res_in.out_count      = prev_children_ff + 1'b1;
                        res_in.out_parents    = prev_parents_ff[mnca_pkg::PARENTS_W-1:0];
                        res_in.out_slot       = send_slot_ff;
                        res_in.out_remaining  = remaining;
                        res_in.out_id         = node_id_ff;
                        res_in.out_clock      = now_ff;
                     end
                  end
               end

               mnca_pkg::MODE_STOP: begin
                  node_active_in = 1'b0;
                  hop_level_in   = mnca_pkg::LEVEL_NONE;
                  prev_level_in  = mnca_pkg::LEVEL_NONE;
                  if (send_accepted_ff) begin
                     send_pending_in  = 1'b1;
                     res_in.send_kind = mnca_pkg::KIND_STOP;
                  end
               end

               default: begin
                  send_pending_in = 1'b0;
               end
            endcase
            res_in.clock_on = node_active_in;
         end

         mnca_pkg::ST_DIV_QUO: begin
            // keep count/parents, then start random word mod parents
            div_dividend = rand_pick_ff;
            if (div_stat.done) begin
               quo_in         = div_stat.quotient;
               rem_in         = div_stat.remainder;
               div_ctrl.start = 1'b1;
               div_ctrl.steps = mnca_pkg::DIV_STEPS_WORD;
               state_in       = mnca_pkg::ST_DIV_PICK;
            end
         end

         mnca_pkg::ST_DIV_PICK: begin
            if (div_stat.done) begin
               child_tally_in = child_tally_ff + share +
                                {{(mnca_pkg::COUNT_W-1){1'b0}}, round_up};
               state_in       = mnca_pkg::ST_FINISH;
            end
         end

         mnca_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = mnca_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mnca_pkg::ST_IDLE;
         end
      endcase
   end

   // shared divider
   mnca_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (msg_parents_ff),
      .stat     (div_stat)
   );

   // control, configuration and node state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= mnca_pkg::ST_IDLE;
         node_id_ff       <= '0;
         epoch_span_ff    <= mnca_pkg::EPOCH_SPAN_RESET;
         expire_limit_ff  <= mnca_pkg::EXPIRE_LIMIT_RESET;
         hop_level_ff     <= mnca_pkg::LEVEL_NONE;
         prev_level_ff    <= mnca_pkg::LEVEL_NONE;
         child_tally_ff   <= '0;
         parent_tally_ff  <= '0;
         prev_children_ff <= '0;
         prev_parents_ff  <= '0;
         idle_epochs_ff   <= '0;
         send_pending_ff  <= 1'b0;
         sent_ff          <= 1'b0;
         node_active_ff   <= 1'b0;
         send_slot_ff     <= '0;
         epoch_start_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         hop_level_ff     <= hop_level_in;
         prev_level_ff    <= prev_level_in;
         child_tally_ff   <= child_tally_in;
         parent_tally_ff  <= parent_tally_in;
         prev_children_ff <= prev_children_in;
         prev_parents_ff  <= prev_parents_in;
         idle_epochs_ff   <= idle_epochs_in;
         send_pending_ff  <= send_pending_in;
         sent_ff          <= sent_in;
         node_active_ff   <= node_active_in;
         send_slot_ff     <= send_slot_in;
         epoch_start_ff   <= epoch_start_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               mnca_pkg::CSR_NODE_ID: begin
                  node_id_ff <= csr_wdata;
               end
               mnca_pkg::CSR_EPOCH_SPAN: begin
                  epoch_span_ff <= csr_wdata[mnca_pkg::EPOCH_W-1:0];
               end
               mnca_pkg::CSR_EXPIRE_LIMIT: begin
                  expire_limit_ff <= csr_wdata[mnca_pkg::LIMIT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // event capture and result payload
   always_ff @(posedge clock) begin
      if (take_beat) begin
         mode_ff          <= req_bus.mode;
         msg_level_ff     <= req_bus.msg_level;
         msg_count_ff     <= req_bus.msg_count;
         msg_parents_ff   <= req_bus.msg_parents;
         msg_remaining_ff <= req_bus.msg_remaining;
         now_ff           <= req_bus.now_time;
         slot_pick_ff     <= req_bus.rand_slot[mnca_pkg::SLOT_LSB +: mnca_pkg::SLOT_W];
         rand_pick_ff     <= req_bus.rand_pick;
         send_accepted_ff <= req_bus.send_accepted;
      end
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // result beat
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.send_kind     = rsp_data_ff.send_kind;
   assign rsp_bus.out_level     = rsp_data_ff.out_level;
   assign rsp_bus.out_count     = rsp_data_ff.out_count;
   assign rsp_bus.out_parents   = rsp_data_ff.out_parents;
   assign rsp_bus.out_slot      = rsp_data_ff.out_slot;
   assign rsp_bus.out_remaining = rsp_data_ff.out_remaining;
   assign rsp_bus.out_id        = rsp_data_ff.out_id;
   assign rsp_bus.out_clock     = rsp_data_ff.out_clock;
   assign rsp_bus.clock_on      = rsp_data_ff.clock_on;

endmodule

`default_nettype wire

@@ rtl/mnca_divider.sv @@
// iterative restoring divider, two quotient bits per cycle
`default_nettype none

module mnca_divider (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire mnca_pkg::div_ctrl_type            ctrl,
   input  wire [mnca_pkg::DIV_DIVIDEND_W-1:0]     dividend,
   input  wire [mnca_pkg::PARENTS_W-1:0]          divisor,
   output mnca_pkg::div_stat_type                 stat
);

   logic [mnca_pkg::DIV_STEP_W-1:0]     cnt_ff, cnt_in;
   logic                                done_ff, done_in;
   logic [mnca_pkg::DIV_DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [mnca_pkg::DIV_QUOTIENT_W-1:0] quo_ff, quo_in;
   logic [mnca_pkg::PARENTS_W-1:0]      rem_ff, rem_in;
   logic [mnca_pkg::PARENTS_W-1:0]      dvs_ff, dvs_in;

   // step logic: shift in a dividend bit, trial subtract, per quotient bit
   always_comb begin
      logic [mnca_pkg::PARENTS_W:0]        trial;
      logic [mnca_pkg::PARENTS_W-1:0]      r;
      logic [mnca_pkg::DIV_QUOTIENT_W-1:0] q;
      logic [mnca_pkg::DIV_DIVIDEND_W-1:0] d;
      logic                                qbit;
      r = rem_ff;
      q = quo_ff;
      d = dvd_ff;
      for (int i = 0; i < mnca_pkg::DIV_BITS_PER_CYCLE; i++) begin
         trial = {r, d[mnca_pkg::DIV_DIVIDEND_W-1]};
         d     = {d[mnca_pkg::DIV_DIVIDEND_W-2:0], 1'b0};
         qbit  = (trial >= {1'b0, dvs_ff});
         if (qbit) begin
            trial = trial - {1'b0, dvs_ff};
         end
         r = trial[mnca_pkg::PARENTS_W-1:0];
         q = {q[mnca_pkg::DIV_QUOTIENT_W-2:0], qbit};
      end

      cnt_in  = cnt_ff;
      done_in = 1'b0;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (ctrl.start) begin
         cnt_in = ctrl.steps;
         dvd_in = dividend;
         dvs_in = divisor;
         quo_in = '0;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == {{(mnca_pkg::DIV_STEP_W-1){1'b0}}, 1'b1});
         dvd_in  = d;
         quo_in  = q;
         rem_in  = r;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.done      = done_ff;
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff;

endmodule

`default_nettype wire

@@ rtl/mnca_checker.sv @@
// port-level checks of the node count aggregator, bound to the top level
`default_nettype none

`include "multihop_node_count_aggregator_top_macros.svh"

module mnca_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_valid,
   input wire                                 req_ready,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire [mnca_pkg::KIND_W-1:0]          rsp_send_kind,
   input wire [mnca_pkg::LEVEL_W-1:0]         rsp_out_level,
   input wire [mnca_pkg::ID_W-1:0]            rsp_out_id,
   input wire [mnca_pkg::TIME_W-1:0]          rsp_out_clock
);

   // a stalled result beat holds its kind
   `MNCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_send_kind))

   // one event at a time: busy right after taking a beat
   `MNCA_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)

   // a new result only appears after the block was busy
   `MNCA_ASSERT_SAME(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(!req_ready))

   // only a count report carries payload
   `MNCA_ASSERT_SAME(a_quiet_payload, clock, reset, rsp_valid && rsp_send_kind != mnca_pkg::KIND_REPORT, rsp_out_level == '0 && rsp_out_id == '0 && rsp_out_clock == '0)

endmodule

bind multihop_node_count_aggregator_top mnca_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_send_kind (rsp_bus.send_kind),
   .rsp_out_level (rsp_bus.out_level),
   .rsp_out_id    (rsp_bus.out_id),
   .rsp_out_clock (rsp_bus.out_clock)
);

`default_nettype wire

@@ bench/multihop_node_count_aggregator_top_tb.sv @@
// self-checking bench for the multihop node count aggregator: directed and random events
`timescale 1ns / 1ps

// one event as driven on the request channel
typedef struct {
   logic [mnca_pkg::MODE_W-1:0]           mode;
   logic signed [mnca_pkg::LEVEL_W-1:0]   level;
   logic signed [mnca_pkg::COUNT_W-1:0]   count;
   logic [mnca_pkg::PARENTS_W-1:0]        parents;
   logic signed [mnca_pkg::TIME_W-1:0]    remaining;
   logic [mnca_pkg::TIME_W-1:0]           now;
   logic [mnca_pkg::RAND_W-1:0]           rand_slot;
   logic [mnca_pkg::RAND_W-1:0]           rand_pick;
   logic                                  accepted;
} node_input_type;

// node counter prediction and the results it still waits for
class aggregator_board;
   // register copies
   logic [mnca_pkg::ID_W-1:0]      station_id;
   logic [mnca_pkg::EPOCH_W-1:0]   epoch_ticks;
   logic [mnca_pkg::LIMIT_W-1:0]   idle_allowance;
   // node state
   logic [mnca_pkg::LEVEL_W-1:0]   my_level;
   logic [mnca_pkg::LEVEL_W-1:0]   last_level;
   logic [mnca_pkg::COUNT_W-1:0]   child_sum;
   logic [mnca_pkg::COUNT_W-1:0]   parent_sum;
   logic [mnca_pkg::COUNT_W-1:0]   last_children;
   logic [mnca_pkg::COUNT_W-1:0]   last_parents;
   logic [7:0]                     quiet_epochs;
   bit                             radio_busy;
   bit                             reported;
   bit                             awake;
   logic [mnca_pkg::SLOT_W-1:0]    report_slot;
   logic [mnca_pkg::TIME_W-1:0]    epoch_base;

   mnca_pkg::rsp_payload_type      awaited_results[$];
   int                             failures;

   function new();
      station_id     = '0;
      epoch_ticks    = mnca_pkg::EPOCH_SPAN_RESET;
      idle_allowance = mnca_pkg::EXPIRE_LIMIT_RESET;
      my_level       = mnca_pkg::LEVEL_NONE;
      last_level     = mnca_pkg::LEVEL_NONE;
      child_sum      = '0;
      parent_sum     = '0;
      last_children  = '0;
      last_parents   = '0;
      quiet_epochs   = '0;
      radio_busy     = 1'b0;
      reported       = 1'b0;
      awake          = 1'b0;
      report_slot    = '0;
      epoch_base     = '0;
      failures       = 0;
   endfunction

   function void write_register(logic [mnca_pkg::CSR_INDEX_W-1:0] index,
                                logic [mnca_pkg::CSR_DATA_W-1:0] value);
      case (index)
         mnca_pkg::CSR_NODE_ID:      station_id     = value;
         mnca_pkg::CSR_EPOCH_SPAN:   epoch_ticks    = value[mnca_pkg::EPOCH_W-1:0];
         mnca_pkg::CSR_EXPIRE_LIMIT: idle_allowance = value[mnca_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // ticks left in the epoch; a negative elapsed time counts as a full epoch
   function int ticks_left(logic [mnca_pkg::TIME_W-1:0] now);
      logic [mnca_pkg::TIME_W-1:0] diff;
      int elapsed;
      diff    = now - epoch_base;
      elapsed = int'($signed(diff));
      if (elapsed < 0) elapsed = int'(epoch_ticks);
      return int'(epoch_ticks) - elapsed;
   endfunction

   // update the node state for one accepted event and queue its result
   function void take_event(node_input_type ev);
      mnca_pkg::rsp_payload_type res;
      int ml, mc, mp, mr, rem, cur, q, r, pick;
      res = '0;
      ml  = int'(ev.level);
      mc  = int'(ev.count);
      mp  = int'(ev.parents);
      mr  = int'(ev.remaining);
      case (ev.mode)
         mnca_pkg::MODE_COUNT: begin
            // first message wakes the node and starts its epoch
            if (!awake) begin
               report_slot = ev.rand_slot[mnca_pkg::SLOT_LSB +: mnca_pkg::SLOT_W];
               epoch_base  = ev.now;
               awake       = 1'b1;
            end
            if (my_level == mnca_pkg::LEVEL_NONE || ml + 1 < int'($signed(my_level)))
               my_level = 8'(ml + 1);
            if (int'($signed(my_level)) == ml + 1) begin
               // parent: resync the epoch and tally it
               if (ticks_left(ev.now) != mr)
                  epoch_base = ev.now - 16'(int'(epoch_ticks) - mr);
               parent_sum   = parent_sum + 8'd1;
               quiet_epochs = '0;
            end else if (int'($signed(last_level)) == ml - 1) begin
               // child: share of its count, remainder rounded at random
               if (mp == 0) begin
                  child_sum = child_sum + 8'(mc);
               end else begin
                  q    = mc / mp;
                  r    = mc % mp;
                  pick = int'(ev.rand_pick) % mp;
                  child_sum = child_sum + 8'(q + ((r > pick) ? 1 : 0));
               end
            end
         end
         mnca_pkg::MODE_TICK: begin
            if (awake) begin
               rem = ticks_left(ev.now);
               if (rem <= 0 && (reported || last_level == mnca_pkg::LEVEL_NONE)) begin
                  // epoch end: roll the tallies over
                  reported      = 1'b0;
                  report_slot   = ev.rand_slot[mnca_pkg::SLOT_LSB +: mnca_pkg::SLOT_W];
                  epoch_base    = ev.now + 16'(rem);
                  last_level    = my_level;
                  last_children = child_sum;
                  last_parents  = parent_sum;
                  child_sum     = '0;
                  parent_sum    = '0;
                  quiet_epochs  = quiet_epochs + 8'd1;
                  if (int'($signed(quiet_epochs)) > int'(idle_allowance)) begin
                     my_level   = mnca_pkg::LEVEL_NONE;
                     last_level = mnca_pkg::LEVEL_NONE;
                     awake      = 1'b0;
                  end
               end else if (last_level != mnca_pkg::LEVEL_NONE) begin
                  cur = int'(epoch_ticks) - rem;
                  if (!reported && !(cur < int'(report_slot) && rem > 0) && !radio_busy
                      && ev.accepted) begin
                     radio_busy        = 1'b1;
                     reported          = 1'b1;
                     res.send_kind     = mnca_pkg::KIND_REPORT;
                     res.out_level     = last_level;
                     res.out_count     = last_children + 8'd1;
                     res.out_parents   = last_parents[mnca_pkg::PARENTS_W-1:0];
                     res.out_slot      = report_slot;
                     res.out_remaining = 16'(rem);
                     res.out_id        = station_id;
                     res.out_clock     = ev.now;
                  end
               end
            end
         end
         mnca_pkg::MODE_STOP: begin
            awake      = 1'b0;
            my_level   = mnca_pkg::LEVEL_NONE;
            last_level = mnca_pkg::LEVEL_NONE;
            if (ev.accepted) begin
               radio_busy    = 1'b1;
               res.send_kind = mnca_pkg::KIND_STOP;
            end
         end
         default: radio_busy = 1'b0;
      endcase
      res.clock_on = awake;
      awaited_results.push_back(res);
   endfunction

   task report(string what);
      failures++;
      if (failures <= 100) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // compare one result beat with the oldest expectation
   task check_result(mnca_pkg::rsp_payload_type got);
      mnca_pkg::rsp_payload_type want;
      if (awaited_results.size() == 0) begin
         report($sformatf("result beat with nothing expected, kind %0d", got.send_kind));
         return;
      end
      want = awaited_results.pop_front();
      if (got.send_kind != want.send_kind)
         report($sformatf("send_kind %0d, want %0d", got.send_kind, want.send_kind));
      if (got.out_level != want.out_level)
         report($sformatf("out_level %0h, want %0h", got.out_level, want.out_level));
      if (got.out_count != want.out_count)
         report($sformatf("out_count %0h, want %0h", got.out_count, want.out_count));
      if (got.out_parents != want.out_parents)
         report($sformatf("out_parents %0h, want %0h", got.out_parents, want.out_parents));
      if (got.out_slot != want.out_slot)
         report($sformatf("out_slot %0h, want %0h", got.out_slot, want.out_slot));
      if (got.out_remaining != want.out_remaining)
         report($sformatf("out_remaining %0h, want %0h", got.out_remaining,
                          want.out_remaining));
      if (got.out_id != want.out_id)
         report($sformatf("out_id %0h, want %0h", got.out_id, want.out_id));
      if (got.out_clock != want.out_clock)
         report($sformatf("out_clock %0h, want %0h", got.out_clock, want.out_clock));
      if (got.clock_on != want.clock_on)
         report($sformatf("clock_on %0d, want %0d", got.clock_on, want.clock_on));
   endtask
endclass

module multihop_node_count_aggregator_top_tb;

   localparam int STALL_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_we;
   logic [mnca_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [mnca_pkg::CSR_DATA_W-1:0]  csr_wdata;

   mnca_req_if req_ch ();
   mnca_rsp_if rsp_ch ();

   aggregator_board              board;
   mnca_pkg::rsp_payload_type    rsp_seen;
   logic [mnca_pkg::TIME_W-1:0]  clock_now;
   int                           parent_pct;
   bit                           calm;
   int                           quiet_cycles;

   multihop_node_count_aggregator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   assign rsp_seen = {rsp_ch.send_kind, rsp_ch.out_level, rsp_ch.out_count, rsp_ch.out_parents,
                      rsp_ch.out_slot, rsp_ch.out_remaining, rsp_ch.out_id, rsp_ch.out_clock,
                      rsp_ch.clock_on};

   // result side: random back-pressure, none during the calm phase
   always @(negedge clock) begin
      rsp_ch.ready = calm || ($urandom_range(0, 99) >= 7);
   end

   // check every accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) board.check_result(rsp_seen);
   end

   // watchdog on cycles with no beat moving on either channel
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("[multihop_node_count_aggregator_top] ERROR");
      $finish;
   end

   function automatic node_input_type make_event(logic [mnca_pkg::MODE_W-1:0] mode, int level,
                                                 int count, int parents, int remaining,
                                                 int now, int rslot, int rpick, bit acc);
      node_input_type ev;
      ev.mode      = mode;
      ev.level     = 8'(level);
      ev.count     = 8'(count);
      ev.parents   = 7'(parents);
      ev.remaining = 16'(remaining);
      ev.now       = 16'(now);
      ev.rand_slot = 16'(rslot);
      ev.rand_pick = 16'(rpick);
      ev.accepted  = acc;
      return ev;
   endfunction

   // random event shaped by the predicted levels and epoch
   function automatic node_input_type random_event();
      node_input_type ev;
      int roll, span;
      ev.mode      = mnca_pkg::MODE_TICK;
      ev.level     = 8'($urandom);
      ev.count     = 8'($urandom);
      ev.parents   = 7'($urandom);
      ev.remaining = 16'($urandom);
      ev.rand_slot = 16'($urandom);
      ev.rand_pick = 16'($urandom);
      ev.accepted  = ($urandom_range(0, 9) != 0);
      roll = $urandom_range(0, 99);
      if (roll < parent_pct) begin
         // message from a parent, mostly in step with our epoch
         ev.mode = mnca_pkg::MODE_COUNT;
         if (board.my_level == mnca_pkg::LEVEL_NONE) ev.level = 8'($urandom_range(0, 6));
         else ev.level = board.my_level - 8'd1;
         case ($urandom_range(0, 3))
            0, 1: ev.remaining = 16'(board.ticks_left(clock_now));
            2:    ev.remaining = 16'(board.ticks_left(clock_now) + $urandom_range(0, 4) - 2);
            default: ;
         endcase
      end else if (roll < parent_pct + 18) begin
         // message from a child
         ev.mode = mnca_pkg::MODE_COUNT;
         if (board.last_level != mnca_pkg::LEVEL_NONE) ev.level = board.last_level + 8'd1;
         if ($urandom_range(0, 3) != 0) ev.count = 8'($urandom_range(1, 12));
         if ($urandom_range(0, 4) != 0) ev.parents = 7'($urandom_range(0, 4));
      end else if (roll < parent_pct + 22) begin
         ev.mode = mnca_pkg::MODE_COUNT;
      end else if (roll < parent_pct + 32) begin
         ev.mode = mnca_pkg::MODE_DONE;
      end else if (roll == 99) begin
         ev.mode = mnca_pkg::MODE_STOP;
      end else begin
         // clock tick: small steps, now and then a jump anywhere
         span = (board.epoch_ticks > 15'd64) ? int'(board.epoch_ticks) / 16 : 2;
         if ($urandom_range(0, 39) == 0) clock_now = 16'($urandom);
         else clock_now = clock_now + 16'($urandom_range(1, span));
      end
      ev.now = clock_now;
      return ev;
   endfunction

   // drive one request beat and note it once taken
   task automatic push_event(input node_input_type ev);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 7) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.mode          = ev.mode;
      req_ch.msg_level     = ev.level;
      req_ch.msg_count     = ev.count;
      req_ch.msg_parents   = ev.parents;
      req_ch.msg_remaining = ev.remaining;
      req_ch.now_time      = ev.now;
      req_ch.rand_slot     = ev.rand_slot;
      req_ch.rand_pick     = ev.rand_pick;
      req_ch.send_accepted = ev.accepted;
      req_ch.valid         = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      board.take_event(ev);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (board.awaited_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [mnca_pkg::CSR_INDEX_W-1:0] index,
                            input logic [mnca_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      board.write_register(index, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      int phase_id[6];
      int phase_epoch[6];
      int phase_limit[6];
      int p, n;
      phase_id    = '{'hFFFF, 'h5A3C, 'h0000, 'hA5C3, 0, 0};
      phase_epoch = '{1, 12, 32767, 0, 20, 9};
      phase_limit = '{0, 127, 3, 10, 5, 2};
      board      = new();
      calm       = 1'b0;
      parent_pct = 15;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_ch.valid         = 1'b0;
      req_ch.mode          = mnca_pkg::MODE_COUNT;
      req_ch.msg_level     = '0;
      req_ch.msg_count     = '0;
      req_ch.msg_parents   = '0;
      req_ch.msg_remaining = '0;
      req_ch.now_time      = '0;
      req_ch.rand_slot     = '0;
      req_ch.rand_pick     = '0;
      req_ch.send_accepted = 1'b0;
      rsp_ch.ready         = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // sleeping node: tick ignored, stop refused then sent, send done
      push_event(make_event(mnca_pkg::MODE_TICK, 0, 0, 0, 0, 50, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_STOP, 0, 0, 0, 0, 51, 'h0000, 0, 0));
      push_event(make_event(mnca_pkg::MODE_STOP, 0, 0, 0, 0, 52, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_DONE, 0, 0, 0, 0, 53, 'h0000, 0, 1));
      // field extremes, level one past the top wraps
      push_event(make_event(mnca_pkg::MODE_COUNT, 127, 127, 127, 32767, 'hFFFF, 'h3F00,
                            'hFFFF, 1));
      push_event(make_event(mnca_pkg::MODE_COUNT, -128, -128, 0, -32768, 0, 'h0000, 0, 0));
      push_event(make_event(mnca_pkg::MODE_STOP, 0, 0, 0, 0, 60, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_DONE, 0, 0, 0, 0, 61, 'h0000, 0, 1));
      // parent at level 0: in step, then resync to both extremes and back
      push_event(make_event(mnca_pkg::MODE_COUNT, 0, 1, 1, 64, 100, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_COUNT, 0, 1, 1, -32768, 110, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_COUNT, 0, 1, 1, 32767, 111, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_COUNT, 0, 1, 1, 60, 120, 'h0000, 0, 1));
      // first epoch end
      push_event(make_event(mnca_pkg::MODE_TICK, 0, 0, 0, 0, 200, 'h0000, 0, 1));
      // children: no parents, extreme split, remainders either way
      push_event(make_event(mnca_pkg::MODE_COUNT, 2, 127, 0, 0, 201, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_COUNT, 2, -128, 127, 0, 201, 'h0000, 'hFFFF, 1));
      push_event(make_event(mnca_pkg::MODE_COUNT, 2, 7, 3, 0, 201, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_COUNT, 2, -7, 3, 0, 201, 'h0000, 2, 1));
      // radio refuses, then report, then nothing more this epoch
      push_event(make_event(mnca_pkg::MODE_TICK, 0, 0, 0, 0, 202, 'h0000, 0, 0));
      push_event(make_event(mnca_pkg::MODE_TICK, 0, 0, 0, 0, 203, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_TICK, 0, 0, 0, 0, 204, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_DONE, 0, 0, 0, 0, 205, 'h0000, 0, 1));
      // next epoch report, then a report held back while the radio is busy
      push_event(make_event(mnca_pkg::MODE_TICK, 0, 0, 0, 0, 244, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_TICK, 0, 0, 0, 0, 245, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_TICK, 0, 0, 0, 0, 308, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_TICK, 0, 0, 0, 0, 309, 'h0000, 0, 1));
      push_event(make_event(mnca_pkg::MODE_DONE, 0, 0, 0, 0, 310, 'h0000, 0, 1));
      clock_now = 16'd310;

      // random phases, each under its own register setting
      for (p = 0; p < 6; p++) begin
         drain_results();
         write_csr(mnca_pkg::CSR_NODE_ID, (p >= 4) ? 16'($urandom) : 16'(phase_id[p]));
         write_csr(mnca_pkg::CSR_EPOCH_SPAN, 16'(phase_epoch[p]));
         write_csr(mnca_pkg::CSR_EXPIRE_LIMIT, 16'(phase_limit[p]));
         calm = (p == 1);
         for (n = 0; n < 240; n++) begin
            // parent traffic comes and goes so that idle epochs pile up
            if (n % 50 == 0) begin
               case ($urandom_range(0, 3))
                  0:       parent_pct = 0;
                  1:       parent_pct = 8;
                  2:       parent_pct = 20;
                  default: parent_pct = 30;
               endcase
            end
            push_event(random_event());
         end
      end
      calm = 1'b0;

      drain_results();
      repeat (24) @(posedge clock);
      if (board.failures == 0)
         $display("[multihop_node_count_aggregator_top] OK");
      else
         $display("[multihop_node_count_aggregator_top] ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mnca_pkg.sv
rtl/mnca_channels.sv
rtl/mnca_divider.sv
rtl/multihop_node_count_aggregator_top.sv
rtl/mnca_checker.sv
bench/multihop_node_count_aggregator_top_tb.sv
